/* rtl/bcc_pkg.sv */
// Shared types and constants for the burst capture controller.
// No dependencies; imported by every module of the block.
package bcc_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int CountW     = 5;
  localparam int SlotW      = 4;
  localparam int AddrW      = 5;

  localparam logic [CountW-1:0] MaxFramesLim = CountW'(MAX_FRAMES);

  typedef enum logic [2:0] {
    MODE_DISABLED  = 3'd0,
    MODE_ARMED     = 3'd1,
    MODE_CAPTURING = 3'd2,
    MODE_READY     = 3'd3,
    MODE_ERROR     = 3'd4
  } mode_e;

  localparam logic [1:0] FUNC_UPDATE  = 2'd0;
  localparam logic [1:0] FUNC_TRIGGER = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  localparam logic [2:0] REASON_NONE   = 3'd0;
  localparam logic [2:0] REASON_FRAMES = 3'd1;
  localparam logic [2:0] REASON_BYTES  = 3'd2;
  localparam logic [2:0] REASON_TIME   = 3'd3;
  localparam logic [2:0] REASON_FAIL   = 3'd4;

  localparam logic [2:0] REG_PRESENT   = 3'd0;
  localparam logic [2:0] REG_INTERVAL  = 3'd1;
  localparam logic [2:0] REG_POST_TRIG = 3'd2;
  localparam logic [2:0] REG_MAX_FRM   = 3'd3;
  localparam logic [2:0] REG_MAX_BYTES = 3'd4;

  typedef struct packed {
    logic              present;
    logic [15:0]       frame_interval;
    logic [15:0]       post_trigger;
    logic [CountW-1:0] max_frames;
    logic [23:0]       max_bytes;
  } cfg_t;

  typedef struct packed {
    logic present_we;
    logic present_val;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [31:0] capture_ms;
    logic        init_ok;
    logic        frame_ok;
    logic [23:0] frame_len;
    logic        store_ok;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } item_t;

  typedef struct packed {
    mode_e             mode;
    logic              pending;
    logic              powered;
    logic [31:0]       last_attempt;
    logic [CountW-1:0] count;
    logic [23:0]       byte_total;
    logic [31:0]       start_time;
    logic [15:0]       last_width;
    logic [15:0]       last_height;
  } state_t;

  typedef struct packed {
    state_t           st;
    logic             store_strobe;
    logic [SlotW-1:0] store_slot;
    logic [2:0]       finish_reason;
  } result_t;

endpackage

/* rtl/bcc_cfg.sv */
// APB register file for the burst capture controller.
// Depends on bcc_pkg for the register map and config struct.
module bcc_cfg import bcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o,
  output cfg_wr_t          cfg_wr_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PRESENT:   cfg_d.present        = pwdata[0];
        REG_INTERVAL:  cfg_d.frame_interval = pwdata[15:0];
        REG_POST_TRIG: cfg_d.post_trigger   = pwdata[15:0];
        REG_MAX_FRM:   cfg_d.max_frames     = pwdata[CountW-1:0];
        REG_MAX_BYTES: cfg_d.max_bytes      = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.present        <= 1'b1;
      cfg_q.frame_interval <= 16'd100;
      cfg_q.post_trigger   <= 16'd1000;
      cfg_q.max_frames     <= CountW'(16);
      cfg_q.max_bytes      <= 24'd1048576;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRESENT:   prdata = {31'd0, cfg_q.present};
      REG_INTERVAL:  prdata = {16'd0, cfg_q.frame_interval};
      REG_POST_TRIG: prdata = {16'd0, cfg_q.post_trigger};
      REG_MAX_FRM:   prdata = {{(32-CountW){1'b0}}, cfg_q.max_frames};
      REG_MAX_BYTES: prdata = {8'd0, cfg_q.max_bytes};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o                = cfg_q;
  assign cfg_wr_o.present_we  = wr_en && (reg_idx == REG_PRESENT);
  assign cfg_wr_o.present_val = pwdata[0];

endmodule

/* rtl/bcc_in_reg.sv */
// Input register stage: holds one accepted item for the sequencer.
// Depends on bcc_pkg for the item struct.
module bcc_in_reg import bcc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // free slot, or the held item moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/bcc_core.sv */
// Burst sequencer state and its single-pass next-state logic.
// Depends on bcc_pkg for state, item, config and result types.
module bcc_core import bcc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  input  cfg_wr_t cfg_wr_i,
  output result_t result_o
);

  state_t st_q, st_d;

  function automatic state_t power_off(state_t s);
    state_t r;
    r = s;
    if (s.powered) begin
      r.powered      = 1'b0;
      r.last_attempt = 32'd0;
    end
    return r;
  endfunction

  function automatic state_t clear_burst(state_t s);
    state_t r;
    r = s;
    r.count       = '0;
    r.byte_total  = '0;
    r.start_time  = '0;
    r.last_width  = '0;
    r.last_height = '0;
    return r;
  endfunction

  logic [31:0]       elapsed;
  logic [31:0]       cap_delta;
  logic [24:0]       byte_sum;
  logic [CountW-1:0] limit;
  logic              strobe;
  logic [SlotW-1:0]  slot;
  logic [2:0]        reason;

  assign elapsed = item_i.now_ms - st_q.last_attempt;
  assign limit   = (cfg_i.max_frames < MaxFramesLim) ? cfg_i.max_frames : MaxFramesLim;

  always_comb begin
    st_d      = st_q;
    strobe    = 1'b0;
    slot      = '0;
    reason    = REASON_NONE;
    cap_delta = '0;
    byte_sum  = '0;
    if (fire_i) begin
      case (item_i.func)
        FUNC_TRIGGER: begin
          if (st_q.mode != MODE_DISABLED) st_d.pending = 1'b1;
        end
        FUNC_CLEAR: begin
          st_d              = clear_burst(st_d);
          st_d.pending      = 1'b0;
          st_d.last_attempt = 32'd0;
          st_d              = power_off(st_d);
          if (st_q.mode != MODE_DISABLED) st_d.mode = MODE_ARMED;
        end
        FUNC_UPDATE: begin
          if (((st_q.mode == MODE_ARMED && st_q.pending) || st_q.mode == MODE_CAPTURING)
              && elapsed >= {16'd0, cfg_i.frame_interval}) begin
            st_d.last_attempt = item_i.now_ms;
            // burst start
            if (st_q.mode == MODE_ARMED) begin
              if (!st_q.powered && !item_i.init_ok) begin
                st_d.mode = MODE_ERROR;
                st_d      = power_off(st_d);
                reason    = REASON_FAIL;
              end else begin
                st_d.powered      = 1'b1;
                st_d              = clear_burst(st_d);
                st_d.start_time   = item_i.now_ms;
                st_d.mode         = MODE_CAPTURING;
                st_d.last_attempt = 32'd0;
              end
            end
            byte_sum  = {1'b0, st_d.byte_total} + {1'b0, item_i.frame_len};
            cap_delta = item_i.capture_ms - st_d.start_time;
            if (!item_i.frame_ok) begin
              st_d.mode = MODE_ERROR;
              st_d      = power_off(st_d);
              reason    = REASON_FAIL;
            end else if (st_d.mode == MODE_CAPTURING) begin
              if (st_d.count >= limit) begin
                reason = REASON_FRAMES;
              end else if (byte_sum > {1'b0, cfg_i.max_bytes}) begin
                reason = REASON_BYTES;
              end else if (!item_i.store_ok) begin
                st_d.mode = MODE_ERROR;
                st_d      = power_off(st_d);
                reason    = REASON_FAIL;
              end else begin
                strobe           = 1'b1;
                slot             = st_d.count[SlotW-1:0];
                st_d.byte_total  = byte_sum[23:0];
                st_d.last_width  = item_i.frame_width;
                st_d.last_height = item_i.frame_height;
                st_d.count       = st_d.count + CountW'(1);
                if (cap_delta >= {16'd0, cfg_i.post_trigger}) reason = REASON_TIME;
              end
              // normal burst end; an empty burst is a failure
              if (reason == REASON_FRAMES || reason == REASON_BYTES
                  || reason == REASON_TIME) begin
                if (st_d.count == '0) begin
                  st_d.mode = MODE_ERROR;
                  reason    = REASON_FAIL;
                end else begin
                  st_d.mode    = MODE_READY;
                  st_d.pending = 1'b0;
                end
                st_d = power_off(st_d);
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (cfg_wr_i.present_we) begin
      if (!cfg_wr_i.present_val) st_d.mode = MODE_DISABLED;
      else if (st_q.mode == MODE_DISABLED) st_d.mode = MODE_ARMED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode         <= MODE_ARMED;
      st_q.pending      <= 1'b0;
      st_q.powered      <= 1'b0;
      st_q.last_attempt <= '0;
      st_q.count        <= '0;
      st_q.byte_total   <= '0;
      st_q.start_time   <= '0;
      st_q.last_width   <= '0;
      st_q.last_height  <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign result_o.st            = st_d;
  assign result_o.store_strobe  = strobe;
  assign result_o.store_slot    = slot;
  assign result_o.finish_reason = reason;

endmodule

/* rtl/burst_capture_controller_unit.sv */
// Top level of the burst capture controller: input stage, sequencer, result register.
// Depends on bcc_pkg, bcc_cfg, bcc_in_reg and bcc_core.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one event per transfer: an update
//   tick, a trigger or a clear, with the camera status fields of that update.
//   Output channel out_valid_o/out_ready_i returns exactly one result per event:
//   mode, trigger flag, camera power, burst counters, store command and finish reason.
//   An accepted event is loaded into the input register and then into the result
//   register, where it becomes valid. Throughput is one event per cycle while the
//   receiver does not stall; the sequencer state is updated as the event moves into
//   the result register.
//   When the receiver stalls the result register holds, the held input waits, and
//   in_ready_o drops once both stages are full; nothing is lost or repeated.
//   Reset empties both stages and puts the sequencer in armed mode with all
//   counters zero; the registers take their documented reset values.
//   The APB port writes the five setup registers at 4-byte spacing; write them
//   only while no event is in flight.
module burst_capture_controller_unit import bcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       func_i,
  input  logic [31:0]      now_ms_i,
  input  logic [31:0]      capture_ms_i,
  input  logic             init_ok_i,
  input  logic             frame_ok_i,
  input  logic [23:0]      frame_len_i,
  input  logic             store_ok_i,
  input  logic [15:0]      frame_width_i,
  input  logic [15:0]      frame_height_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       status_o,
  output logic             trigger_pending_o,
  output logic             camera_on_o,
  output logic [CountW-1:0] frame_count_o,
  output logic [23:0]      total_bytes_o,
  output logic [31:0]      burst_start_ms_o,
  output logic [15:0]      burst_width_o,
  output logic [15:0]      burst_height_o,
  output logic             store_strobe_o,
  output logic [SlotW-1:0] store_slot_o,
  output logic [2:0]       finish_reason_o
);

  cfg_t    cfg;
  cfg_wr_t cfg_wr;
  item_t   item_in, item_q;
  logic    item_valid;
  logic    advance;
  logic    fire;
  result_t result;
  result_t res_q;
  logic    out_valid_q;

  assign item_in.func         = func_i;
  assign item_in.now_ms       = now_ms_i;
  assign item_in.capture_ms   = capture_ms_i;
  assign item_in.init_ok      = init_ok_i;
  assign item_in.frame_ok     = frame_ok_i;
  assign item_in.frame_len    = frame_len_i;
  assign item_in.store_ok     = store_ok_i;
  assign item_in.frame_width  = frame_width_i;
  assign item_in.frame_height = frame_height_i;

  assign advance = !out_valid_q || out_ready_i;
  assign fire    = item_valid && advance;

  bcc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .cfg_wr_o (cfg_wr)
  );

  bcc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (item_in),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item_q)
  );

  bcc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .cfg_wr_i (cfg_wr),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q.st.mode;
  assign trigger_pending_o = res_q.st.pending;
  assign camera_on_o       = res_q.st.powered;
  assign frame_count_o     = res_q.st.count;
  assign total_bytes_o     = res_q.st.byte_total;
  assign burst_start_ms_o  = res_q.st.start_time;
  assign burst_width_o     = res_q.st.last_width;
  assign burst_height_o    = res_q.st.last_height;
  assign store_strobe_o    = res_q.store_strobe;
  assign store_slot_o      = res_q.store_slot;
  assign finish_reason_o   = res_q.finish_reason;

endmodule

/* rtl/bcc_checker.sv */
// Port-level checks for burst_capture_controller_unit, attached by bind.
// Depends on bcc_pkg for mode and finish reason codes.
module bcc_checker import bcc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [2:0]       status_o,
  input logic             camera_on_o,
  input logic             store_strobe_o,
  input logic [SlotW-1:0] store_slot_o,
  input logic [2:0]       finish_reason_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(finish_reason_o))
    else $error("result changed while stalled");

  // a stored frame leaves the block capturing or, on the time limit, ready
  a_strobe_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_strobe_o |->
      status_o == MODE_CAPTURING || status_o == MODE_READY)
    else $error("store command outside a burst");

  a_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !store_strobe_o |-> store_slot_o == '0)
    else $error("slot set without store command");

  // a normal burst end leaves the camera off and the block ready
  a_finish_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (finish_reason_o == REASON_FRAMES || finish_reason_o == REASON_BYTES
      || finish_reason_o == REASON_TIME) |-> status_o == MODE_READY && !camera_on_o)
    else $error("burst end without ready mode");

  a_fail_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finish_reason_o == REASON_FAIL |->
      status_o == MODE_ERROR && !camera_on_o)
    else $error("failure without error mode");

endmodule

bind burst_capture_controller_unit bcc_checker u_bcc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .camera_on_o     (camera_on_o),
  .store_strobe_o  (store_strobe_o),
  .store_slot_o    (store_slot_o),
  .finish_reason_o (finish_reason_o)
);
